FILE: src/twtc_pkg.sv
// Package for the timed window travel controller.
// Holds widths, scale constant, codes and the control/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twtc_pkg;

	localparam int FULL_SCALE = 10000;

	localparam int PCT_W     = 14;
	localparam int ELAPSED_W = 24;
	localparam int TIME_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;

	localparam int FS_W    = $clog2(FULL_SCALE + 1);
	localparam int PROD_W  = ELAPSED_W + FS_W;
	localparam int CNT_W   = $clog2(PROD_W);
	localparam int SUM_W   = ((FS_W > PCT_W) ? FS_W : PCT_W) + 2;

	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 2'd3;

	localparam logic [TIME_W-1:0] OPEN_TIME_RST  = 20'd30000;
	localparam logic [TIME_W-1:0] CLOSE_TIME_RST = 20'd30000;
	localparam logic [PCT_W-1:0]  LEAD_RST       = 14'd200;
	localparam logic [PCT_W-1:0]  DEADBAND_RST   = 14'd100;

	typedef enum logic [1:0] {
		MOT_IDLE    = 2'd0,
		MOT_OPENING = 2'd1,
		MOT_CLOSING = 2'd2
	} motion_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2
	} command_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_POS,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [PCT_W-1:0]     start_pct;
		logic [ELAPSED_W-1:0] elapsed_ms;
		logic [PCT_W-1:0]     target_pct;
		logic                 settle_ok;
	} twtc_in_t;

	typedef struct packed {
		logic [PCT_W-1:0] position_pct;
		logic [1:0]       command;
		logic             reached;
		logic [1:0]       new_motion;
	} twtc_out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input transfer
		logic mul;       // form dividend, clear divider
		logic div_step;  // one quotient bit
		logic pos;       // register clamped position
		logic fin;       // decide, write result, update motion
	} twtc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip_div;  // idle or zero travel time
		logic div_last;  // final quotient bit this cycle
		logic out_free;  // result register can take a new result
	} twtc_sts_t;

endpackage : twtc_pkg

`default_nettype wire

FILE: src/twtc_ctrl.sv
// Sequencer for the travel controller: load, multiply, divide, clamp, decide.
// Depends on twtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twtc_ctrl
	import twtc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire twtc_sts_t sts,
	output twtc_cmd_t      cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = sts.skip_div ? ST_POS : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_POS;
				end
			end
			ST_POS: begin
				cmd.pos   = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// divider keeps running until its last bit
	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> (state_q == ST_DIV))
		else $error("divider left early");

	// a finished result waits for the result register
	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !sts.out_free) |=> (state_q == ST_FIN))
		else $error("result dropped while output full");

	// only one item in flight: after load nothing is accepted until the result is written
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (in_stall && !cmd.fin))
		else $error("second item accepted during work");

endmodule : twtc_ctrl

`default_nettype wire

FILE: src/twtc_dpath.sv
// Datapath: config registers, scale multiply, bit-serial divider, clamp,
// direction decision, motion state and result register. Depends on twtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twtc_dpath
	import twtc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire twtc_in_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output twtc_out_t                 out_data,
	input  wire twtc_cmd_t            cmd,
	output twtc_sts_t                 sts
);

	// configuration
	logic [TIME_W-1:0] open_time_q, close_time_q;
	logic [PCT_W-1:0]  lead_q, band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_time_q  <= OPEN_TIME_RST;
			close_time_q <= CLOSE_TIME_RST;
			lead_q       <= LEAD_RST;
			band_q       <= DEADBAND_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_OPEN_TIME:  open_time_q  <= cfg_data[TIME_W-1:0];
				REG_CLOSE_TIME: close_time_q <= cfg_data[TIME_W-1:0];
				REG_LEAD:       lead_q       <= cfg_data[PCT_W-1:0];
				REG_DEADBAND:   band_q       <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// motion state
	motion_t motion_q, motion_nxt;

	// captured item
	logic [PCT_W-1:0]     start_q, target_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 settle_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q   <= in_data.start_pct;
			elapsed_q <= in_data.elapsed_ms;
			target_q  <= in_data.target_pct;
			settle_q  <= in_data.settle_ok;
		end
	end

	// divider: dvd_q holds dividend bits, then quotient bits
	logic [PROD_W-1:0] dvd_q;
	logic [TIME_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] divisor;
	logic [TIME_W:0]   rem_sh, trial;
	logic              fits;

	assign divisor = (motion_q == MOT_OPENING) ? open_time_q : close_time_q;
	assign rem_sh  = {rem_q, dvd_q[PROD_W-1]};
	assign trial   = rem_sh - {1'b0, divisor};
	assign fits    = (rem_sh >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			dvd_q <= PROD_W'(elapsed_q) * PROD_W'(FULL_SCALE);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? trial[TIME_W-1:0] : rem_sh[TIME_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], fits};
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign sts.skip_div = !((motion_q == MOT_OPENING && open_time_q != '0) ||
	                        (motion_q == MOT_CLOSING && close_time_q != '0));
	assign sts.div_last = (cnt_q == CNT_W'(PROD_W - 1));

	// skip flag for the clamp stage, set when the divider is bypassed
	logic skip_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			skip_q <= sts.skip_div;
		end
	end

	// position estimate and clamp
	logic [SUM_W-1:0]  start_w, raw, clamped;
	logic [FS_W-1:0]   pos_q;

	assign start_w = SUM_W'(start_q);

	always_comb begin
		raw = start_w;
		if (!skip_q) begin
			if (motion_q == MOT_OPENING) begin
				if (dvd_q >= PROD_W'(FULL_SCALE)) begin
					raw = SUM_W'(FULL_SCALE);
				end else begin
					raw = start_w + SUM_W'(dvd_q[FS_W-1:0]);
				end
			end else begin
				if (dvd_q > PROD_W'(start_q)) begin
					raw = '0;
				end else begin
					raw = start_w - SUM_W'(dvd_q[PCT_W-1:0]);
				end
			end
		end
		clamped = (raw > SUM_W'(FULL_SCALE)) ? SUM_W'(FULL_SCALE) : raw;
	end

	always_ff @(posedge clk) begin
		if (cmd.pos) begin
			pos_q <= clamped[FS_W-1:0];
		end
	end

	// direction decision, signed compares
	logic signed [SUM_W-1:0] p_s, t_s, t_lo_lead, t_hi_lead, t_lo_band, t_hi_band;
	logic                    full_open, full_close;
	command_t                cmd_code;
	logic                    reached;

	assign p_s       = signed'(SUM_W'(pos_q));
	assign t_s       = signed'(SUM_W'(target_q));
	assign t_lo_lead = t_s - signed'(SUM_W'(lead_q));
	assign t_hi_lead = t_s + signed'(SUM_W'(lead_q));
	assign t_lo_band = t_s - signed'(SUM_W'(band_q));
	assign t_hi_band = t_s + signed'(SUM_W'(band_q));
	assign full_open  = (SUM_W'(target_q) >= SUM_W'(FULL_SCALE));
	assign full_close = (target_q == '0);

	always_comb begin
		cmd_code   = CMD_NONE;
		motion_nxt = motion_q;
		reached    = 1'b0;
		unique case (motion_q)
			MOT_OPENING: begin
				if (full_open) begin
					if (SUM_W'(pos_q) >= SUM_W'(FULL_SCALE)) begin
						motion_nxt = MOT_IDLE;
						reached    = 1'b1;
					end
				end else if (p_s >= t_lo_lead) begin
					cmd_code   = CMD_CLOSE;
					motion_nxt = MOT_IDLE;
					reached    = (p_s <= t_hi_band);
				end
			end
			MOT_CLOSING: begin
				if (full_close) begin
					if (pos_q == '0) begin
						motion_nxt = MOT_IDLE;
						reached    = 1'b1;
					end
				end else if (p_s <= t_hi_lead) begin
					cmd_code   = CMD_OPEN;
					motion_nxt = MOT_IDLE;
					reached    = (p_s >= t_lo_band);
				end
			end
			default: begin
				// idle, and the unused code behaves as idle
				motion_nxt = MOT_IDLE;
				if (p_s > t_lo_band && p_s < t_hi_band) begin
					reached = 1'b1;
				end else if (settle_q) begin
					if (t_s > p_s) begin
						cmd_code   = CMD_OPEN;
						motion_nxt = MOT_OPENING;
					end else begin
						cmd_code   = CMD_CLOSE;
						motion_nxt = MOT_CLOSING;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= MOT_IDLE;
		end else if (cmd.fin) begin
			motion_q <= motion_nxt;
		end
	end

	// result register
	logic      out_valid_q;
	twtc_out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.position_pct <= PCT_W'(pos_q);
			out_q.command      <= cmd_code;
			out_q.reached      <= reached;
			out_q.new_motion   <= motion_nxt;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule : twtc_dpath

`default_nettype wire

FILE: src/timed_window_travel_controller.sv
// Top level of the timed window travel controller.
// Joins twtc_ctrl and twtc_dpath; depends on twtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer carries the position at which the current travel began,
// the milliseconds since, a target and a settle flag. The block estimates the
// position as start +/- elapsed * FULL_SCALE / travel_time for the stored
// direction (idle or a zero travel time keeps start), clamps it to
// 0..FULL_SCALE and runs the direction machine, returning one result transfer
// per item: position, open/close/no command, reached flag and new direction.
// One item is worked at a time. An item that needs the estimate passes
// through accept, multiply, one divider step per bit of the PROD_W = 38
// bit dividend, clamp and decision, and its result is registered when the
// decision is made. The next item is accepted in the cycle after its
// predecessor's result is written. When idle or with a zero travel time
// the divider is skipped: accept, multiply, clamp and decision.
// The bit-serial restoring divider produces one quotient bit per cycle.
// The result sits in an output register, so a stalled result does
// not block the next item until that item's own result is ready.
// Configuration registers (index: 0 open time, 1 close time, 2 lead,
// 3 deadband) are written with cfg_wr_en; write them only while no item is
// in flight.
module timed_window_travel_controller
	import twtc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// configuration write port
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,

	// input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire twtc_in_t             in_data,

	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output twtc_out_t                 out_data
);

	twtc_cmd_t cmd;
	twtc_sts_t sts;

	// sequencer: owns the input handshake and steps the datapath
	twtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: registers, divider, decision and result register
	twtc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule : timed_window_travel_controller

`default_nettype wire

FILE: verif/timed_window_travel_controller_test.sv
// Self-checking testbench for timed_window_travel_controller.
// Directed table, then travel sequences under random idling; depends on twtc_pkg and the RTL.
`timescale 1ns / 1ps

module timed_window_travel_controller_test;
	import twtc_pkg::*;

	localparam int          CLK_PERIOD      = 10;
	localparam int unsigned RUN_LIMIT       = 1_000_000; // cycles, far above the slowest run
	localparam int unsigned ITEM_LATENCY    = 41;        // accept to result
	localparam int unsigned IDLE_PAUSE      = 4;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned PHASE_ITEMS     = 75;
	localparam int unsigned PHASES          = 8;

	// directed table rows: an input transfer or a register write
	typedef enum logic {ROW_ITEM, ROW_REG} plan_kind_t;

	typedef struct {
		plan_kind_t            kind;
		twtc_in_t              item;
		logic                  has_want;  // expected result typed in the row
		twtc_out_t             want;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DAT_W-1:0]  reg_val;
	} plan_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	twtc_in_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	twtc_out_t            out_data;

	// predictor copy of the block: direction state and the four registers
	motion_t           motion_now     = MOT_IDLE;
	logic [TIME_W-1:0] open_time_cfg  = OPEN_TIME_RST;
	logic [TIME_W-1:0] close_time_cfg = CLOSE_TIME_RST;
	logic [PCT_W-1:0]  lead_cfg       = LEAD_RST;
	logic [PCT_W-1:0]  band_cfg       = DEADBAND_RST;

	// travel currently being played out by the stimulus
	logic [PCT_W-1:0]     trip_start    = '0;
	logic [PCT_W-1:0]     trip_target   = '0;
	logic [ELAPSED_W-1:0] trip_elapsed  = '0;
	logic [PCT_W-1:0]     last_position = '0;

	twtc_out_t   pending_results[$];
	plan_row_t   plan[$];
	int unsigned err_count    = 0;
	int unsigned result_count = 0;
	int unsigned cycle_count  = 0;
	logic        hold_off_req = 1'b0; // asks the result sink for one long hold-off
	logic        no_idle      = 1'b0; // both sides run back to back

	timed_window_travel_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Position estimate and direction decision for one input transfer.
	// Updates the predicted direction state as the block does.
	function automatic twtc_out_t predict_travel_step(input twtc_in_t it);
		twtc_out_t         res;
		longint            pos;
		longint            tgt;
		longint            lead;
		longint            band;
		longint unsigned   scaled;
		logic              full_open;
		logic              full_close;
		logic              hit;
		command_t          cmd;
		motion_t           nxt;
		scaled = longint'(it.elapsed_ms) * FULL_SCALE;
		pos    = longint'(it.start_pct);
		if (motion_now == MOT_OPENING && open_time_cfg != 0) begin
			pos = pos + longint'(scaled / open_time_cfg);
		end else if (motion_now == MOT_CLOSING && close_time_cfg != 0) begin
			pos = pos - longint'(scaled / close_time_cfg);
		end
		// clamp also covers a start beyond full scale
		if (pos < 0) pos = 0;
		if (pos > FULL_SCALE) pos = FULL_SCALE;
		tgt        = longint'(it.target_pct);
		lead       = longint'(lead_cfg);
		band       = longint'(band_cfg);
		full_open  = (tgt >= FULL_SCALE);
		full_close = (tgt == 0);
		cmd        = CMD_NONE;
		nxt        = motion_now;
		hit        = 1'b0;
		case (motion_now)
			MOT_OPENING: begin
				if (full_open) begin
					// run into the end stop, no stop command
					if (pos >= FULL_SCALE) begin
						nxt = MOT_IDLE;
						hit = 1'b1;
					end
				end else if (pos >= tgt - lead) begin
					cmd = CMD_CLOSE;
					nxt = MOT_IDLE;
					hit = (pos <= tgt + band);
				end
			end
			MOT_CLOSING: begin
				if (full_close) begin
					if (pos <= 0) begin
						nxt = MOT_IDLE;
						hit = 1'b1;
					end
				end else if (pos <= tgt + lead) begin
					cmd = CMD_OPEN;
					nxt = MOT_IDLE;
					hit = (pos >= tgt - band);
				end
			end
			default: begin
				// idle; an unused code behaves the same
				nxt = MOT_IDLE;
				if (pos > tgt - band && pos < tgt + band) begin
					hit = 1'b1;
				end else if (it.settle_ok) begin
					if (tgt > pos) begin
						cmd = CMD_OPEN;
						nxt = MOT_OPENING;
					end else begin
						cmd = CMD_CLOSE;
						nxt = MOT_CLOSING;
					end
				end
			end
		endcase
		motion_now       = nxt;
		res.position_pct = pos[PCT_W-1:0];
		res.command      = cmd;
		res.reached      = hit;
		res.new_motion   = nxt;
		return res;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [CFG_DAT_W-1:0] pick_travel_time();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return CFG_DAT_W'(1);
		if (r < 30) return '1;
		return CFG_DAT_W'($urandom_range(100, 60000));
	endfunction

	// lead and deadband; full-width data checks the register truncation
	function automatic logic [CFG_DAT_W-1:0] pick_margin();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 25) return CFG_DAT_W'(FULL_SCALE);
		if (r < 30) return CFG_DAT_W'((1 << PCT_W) - 1);
		if (r < 40) return CFG_DAT_W'($urandom);
		return CFG_DAT_W'($urandom_range(0, 500));
	endfunction

	function automatic logic [PCT_W-1:0] pick_position();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return PCT_W'(FULL_SCALE);
		if (r < 25) return PCT_W'($urandom);
		return PCT_W'($urandom_range(0, FULL_SCALE));
	endfunction

	// Next stimulus item. Most items play out a travel: a start from idle,
	// then growing elapsed times with the same start until the block stops.
	// The rest is noise or a target moved in mid-travel.
	function automatic twtc_in_t make_travel_item();
		twtc_in_t        it;
		int unsigned     r;
		int unsigned     tt;
		int              t;
		longint unsigned el;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			it.start_pct  = PCT_W'($urandom);
			it.elapsed_ms = ELAPSED_W'($urandom);
			it.target_pct = PCT_W'($urandom);
			it.settle_ok  = 1'($urandom);
			trip_start    = it.start_pct;
			trip_target   = it.target_pct;
			trip_elapsed  = it.elapsed_ms;
		end else if (motion_now == MOT_IDLE) begin
			trip_start = (r < 60) ? last_position : pick_position();
			if (r < 30) begin
				// target near the start: deadband territory
				t = int'(trip_start) + int'($urandom_range(0, 600)) - 300;
				if (t < 0) t = 0;
				trip_target = PCT_W'(t);
			end else begin
				trip_target = pick_position();
			end
			trip_elapsed  = '0;
			it.start_pct  = trip_start;
			it.elapsed_ms = ELAPSED_W'($urandom_range(0, 100));
			it.target_pct = trip_target;
			it.settle_ok  = ($urandom_range(0, 9) != 0);
		end else begin
			tt = 32'((motion_now == MOT_OPENING) ? open_time_cfg : close_time_cfg);
			el = trip_elapsed + $urandom_range(0, (tt == 0) ? 5000 : tt / 3 + 1);
			if (el > (1 << ELAPSED_W) - 1) el = (1 << ELAPSED_W) - 1;
			trip_elapsed = el[ELAPSED_W-1:0];
			if (r < 17) trip_target = pick_position();
			it.start_pct  = trip_start;
			it.elapsed_ms = trip_elapsed;
			it.target_pct = trip_target;
			it.settle_ok  = 1'($urandom);
		end
		return it;
	endfunction

	task automatic report_fail(input string msg);
		$display("mismatch: %s", msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input int unsigned n,
			input logic [PCT_W-1:0] got, input logic [PCT_W-1:0] want);
		if (got !== want) begin
			report_fail($sformatf("result %0d: %s is %0d, expected %0d", n, name, got, want));
		end
	endtask

	// Offer one item after a gap and hold it until the transfer; the
	// expectation is queued at the accepting edge.
	task automatic send_item(input twtc_in_t it, input int unsigned gap,
			input logic use_want, input twtc_out_t want);
		twtc_out_t predicted;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		predicted = predict_travel_step(it);
		pending_results.push_back(use_want ? want : predicted);
		last_position = predicted.position_pct;
	endtask

	// Stop offering and let every outstanding result come back.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_OPEN_TIME:  open_time_cfg  = val[TIME_W-1:0];
			REG_CLOSE_TIME: close_time_cfg = val[TIME_W-1:0];
			REG_LEAD:       lead_cfg       = val[PCT_W-1:0];
			REG_DEADBAND:   band_cfg       = val[PCT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_travel_config(input logic [CFG_DAT_W-1:0] open_ms,
			input logic [CFG_DAT_W-1:0] close_ms, input logic [CFG_DAT_W-1:0] lead,
			input logic [CFG_DAT_W-1:0] band);
		write_reg(REG_OPEN_TIME, open_ms);
		write_reg(REG_CLOSE_TIME, close_ms);
		write_reg(REG_LEAD, lead);
		write_reg(REG_DEADBAND, band);
	endtask

	// table row builders
	task automatic plan_travel(input int unsigned start, input int unsigned elapsed,
			input int unsigned target, input logic settle);
		plan_row_t row;
		row.kind            = ROW_ITEM;
		row.item.start_pct  = PCT_W'(start);
		row.item.elapsed_ms = ELAPSED_W'(elapsed);
		row.item.target_pct = PCT_W'(target);
		row.item.settle_ok  = settle;
		row.has_want        = 1'b0;
		row.want            = '0;
		row.reg_idx         = '0;
		row.reg_val         = '0;
		plan.push_back(row);
	endtask

	task automatic plan_known(input int unsigned start, input int unsigned elapsed,
			input int unsigned target, input logic settle, input int unsigned pos,
			input command_t cmd, input logic hit, input motion_t mot);
		plan_travel(start, elapsed, target, settle);
		plan[$].has_want          = 1'b1;
		plan[$].want.position_pct = PCT_W'(pos);
		plan[$].want.command      = cmd;
		plan[$].want.reached      = hit;
		plan[$].want.new_motion   = mot;
	endtask

	task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		plan_row_t row;
		row.kind     = ROW_REG;
		row.item     = '0;
		row.has_want = 1'b0;
		row.want     = '0;
		row.reg_idx  = idx;
		row.reg_val  = CFG_DAT_W'(val);
		plan.push_back(row);
	endtask

	// Result sink: random stalls, one long hold-off on request, none when
	// no_idle is set. The hold-off is counted here, so the sender keeps
	// offering and the block backs up into in_stall.
	initial begin : result_sink
		int unsigned n;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (no_idle) begin
				out_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Every result transfer is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		twtc_out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report_fail($sformatf("result %0d arrived with nothing expected", result_count));
			end else begin
				want = pending_results.pop_front();
				check_field("position_pct", result_count, out_data.position_pct, want.position_pct);
				check_field("command", result_count, PCT_W'(out_data.command),
					PCT_W'(want.command));
				check_field("reached", result_count, PCT_W'(out_data.reached),
					PCT_W'(want.reached));
				check_field("new_motion", result_count, PCT_W'(out_data.new_motion),
					PCT_W'(want.new_motion));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** timed_window_travel_controller: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int unsigned gap;
		int unsigned phase;

		// Directed table at reset settings (30000 ms both ways, lead 200,
		// deadband 100): one ms of travel moves a third of a hundredth percent.
		plan_known(5000, 0, 5000, 1'b0, 5000, CMD_NONE, 1'b1, MOT_IDLE);      // idle, in band
		plan_known(16383, 24'hFFFFFF, 0, 1'b0,                             // start above full
			FULL_SCALE, CMD_NONE, 1'b0, MOT_IDLE);                             // scale, no settle
		plan_known(0, 0, FULL_SCALE, 1'b1, 0, CMD_OPEN, 1'b0, MOT_OPENING);
		plan_known(0, 15000, FULL_SCALE, 1'b0, 5000, CMD_NONE, 1'b0, MOT_OPENING);
		plan_known(0, 24'hFFFFFF, FULL_SCALE, 1'b0,                         // open end stop
			FULL_SCALE, CMD_NONE, 1'b1, MOT_IDLE);
		plan_known(FULL_SCALE, 0, 0, 1'b1, FULL_SCALE, CMD_CLOSE, 1'b0, MOT_CLOSING);
		plan_known(FULL_SCALE, 3000, 0, 1'b0, 9000, CMD_NONE, 1'b0, MOT_CLOSING);
		plan_known(FULL_SCALE, 24'hFFFFFF, 0, 1'b0, 0, CMD_NONE, 1'b1, MOT_IDLE); // close stop
		plan_known(2000, 0, 6000, 1'b1, 2000, CMD_OPEN, 1'b0, MOT_OPENING);
		plan_travel(2000, 11400, 6000, 1'b0);      // lands exactly on target - lead
		plan_travel(5800, 0, 6000, 1'b0);          // idle out of band, no settle
		plan_travel(8000, 0, 3000, 1'b1);
		plan_travel(8000, 15000, 3000, 1'b1);      // closing stop inside deadband
		plan_travel(3000, 0, 7000, 1'b1);
		plan_travel(3000, 30000, 7000, 1'b0);      // overshoot, stop not reached
		plan_travel(4000, 0, 4100, 1'b1);          // band edge is exclusive
		plan_travel(4000, 0, 16383, 1'b0);         // target beyond full scale counts as full open
		plan_travel(4000, 18000, 16383, 1'b0);
		plan_travel(4000, 0, 4000, 1'b1);
		plan_travel(4000, 0, 3900, 1'b1);
		plan_travel(4000, 0, 3900, 1'b0);
		// zero travel times freeze the estimate at the clamped start position
		plan_reg(REG_OPEN_TIME, 0);
		plan_reg(REG_CLOSE_TIME, 0);
		plan_travel(1000, 0, 9000, 1'b1);
		plan_travel(1000, 24'hFFFFFF, 9000, 1'b0);
		plan_travel(12000, 5, 9000, 1'b0);
		plan_travel(9000, 0, 0, 1'b1);
		plan_travel(9000, 24'hFFFFFF, 0, 1'b0);
		plan_travel(0, 0, 0, 1'b0);
		plan_reg(REG_OPEN_TIME, 32'(OPEN_TIME_RST));
		plan_reg(REG_CLOSE_TIME, 32'(CLOSE_TIME_RST));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				gap = pick_gap();
				send_item(plan[i].item, gap, plan[i].has_want, plan[i].want);
			end
		end

		// Random travels, one register setting per phase: reset settings, then extremes, then random.
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: set_travel_config(OPEN_TIME_RST, CLOSE_TIME_RST,
					CFG_DAT_W'(LEAD_RST), CFG_DAT_W'(DEADBAND_RST));
				1: set_travel_config(CFG_DAT_W'(1), '1, '0, '0);
				2: set_travel_config('1, CFG_DAT_W'(1), CFG_DAT_W'(FULL_SCALE),
					CFG_DAT_W'(FULL_SCALE));
				3: set_travel_config('0, CFG_DAT_W'(30000),
					CFG_DAT_W'((1 << PCT_W) - 1), '0);
				4: set_travel_config(CFG_DAT_W'(500), '0, CFG_DAT_W'(50),
					CFG_DAT_W'((1 << PCT_W) - 1));
				default: set_travel_config(pick_travel_time(), pick_travel_time(),
					pick_margin(), pick_margin());
			endcase
			if (phase == 1) hold_off_req = 1'b1;  // long receiver hold-off
			no_idle = (phase == 2);               // back-to-back stretch
			repeat (PHASE_ITEMS) begin
				gap = no_idle ? 0 : pick_gap();
				send_item(make_travel_item(), gap, 1'b0, '0);
			end
		end
		no_idle = 1'b0;

		wait_idle();
		// any result past this point has no expectation and is flagged
		repeat (2 * ITEM_LATENCY) @(posedge clk);

		if (err_count == 0 && pending_results.size() == 0) begin
			$display("** timed_window_travel_controller: PASSED **");
		end else begin
			$display("** timed_window_travel_controller: FAILED **");
		end
		$finish;
	end

endmodule

FILE: files.f
src/twtc_pkg.sv
src/twtc_ctrl.sv
src/twtc_dpath.sv
src/timed_window_travel_controller.sv
verif/timed_window_travel_controller_test.sv
